// ===== rtl/b32d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32d_pkg
// Shared types and constants for the base32 decoder.
// ----------------------------------------------------------------------------
package b32d_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SYM_W   = 5;
    localparam int unsigned STORE_W = 7;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned BYTES_W = 16;

    localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_PAD     = 8'h3d;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_2 = 8'd50;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_7 = 8'h37;
    localparam logic [SYM_W-1:0]  DIGIT_BASE   = 5'h1a;

    localparam logic [BYTES_W-1:0] BYTES_MAX = 16'hffff;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef struct packed {
        logic             is_term;
        logic             is_sym;
        logic [SYM_W-1:0] value;
    } t_sym;

    typedef struct packed {
        logic               valid;
        t_kind              kind;
        logic [BYTE_W-1:0]  data;
        logic [BYTES_W-1:0] count;
    } t_result;

endpackage

// ===== rtl/b32d_symbol_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32d_symbol_map
// Classifies one character: terminator, alphabet symbol with its 5-bit value,
// or invalid.
// ----------------------------------------------------------------------------
module b32d_symbol_map (
    input  logic [b32d_pkg::CHAR_W-1:0] i_char,
    output b32d_pkg::t_sym              o_sym
);

    logic [b32d_pkg::CHAR_W-1:0] letter_off;
    logic [b32d_pkg::CHAR_W-1:0] digit_off;
    logic                        is_letter;
    logic                        is_digit;

    always_comb begin
        letter_off = i_char - b32d_pkg::CHAR_UPPER_A;
        digit_off  = i_char - b32d_pkg::CHAR_DIGIT_2;
        is_letter  = (i_char >= b32d_pkg::CHAR_UPPER_A) && (i_char <= b32d_pkg::CHAR_UPPER_Z);
        is_digit   = (i_char >= b32d_pkg::CHAR_DIGIT_2) && (i_char <= b32d_pkg::CHAR_DIGIT_7);

        o_sym.is_term = (i_char == b32d_pkg::CHAR_NUL) || (i_char == b32d_pkg::CHAR_PAD);
        o_sym.is_sym  = is_letter || is_digit;
        if (is_letter) begin
            o_sym.value = letter_off[b32d_pkg::SYM_W-1:0];
        end else if (is_digit) begin
            o_sym.value = digit_off[b32d_pkg::SYM_W-1:0] + b32d_pkg::DIGIT_BASE;
        end else begin
            o_sym.value = '0;
        end
    end

endmodule

// ===== rtl/b32d_bit_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32d_bit_packer
// Holds leftover bits, their count and the byte count of the current string;
// forms the result for one classified character and updates on advance.
// ----------------------------------------------------------------------------
module b32d_bit_packer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  b32d_pkg::t_sym      i_sym,
    output b32d_pkg::t_result   o_result
);

    localparam int unsigned ACC_W  = b32d_pkg::STORE_W + b32d_pkg::SYM_W;
    localparam int unsigned BITS_W = b32d_pkg::CNT_W + 1;

    logic [b32d_pkg::STORE_W-1:0] r_store, n_store;
    logic [b32d_pkg::CNT_W-1:0]   r_count, n_count;
    logic [b32d_pkg::BYTES_W-1:0] r_bytes, n_bytes;

    logic [ACC_W-1:0]  acc;
    logic [BITS_W-1:0] bits;
    logic [BITS_W-1:0] rest;
    logic [ACC_W-1:0]  shifted;
    logic [ACC_W-1:0]  mask;

    always_comb begin
        acc     = {r_store, i_sym.value};
        bits    = {1'b0, r_count} + BITS_W'(b32d_pkg::SYM_W);
        rest    = bits - BITS_W'(b32d_pkg::BYTE_W);
        shifted = acc >> rest;
        mask    = (ACC_W'(1) << rest) - ACC_W'(1);

        n_store         = r_store;
        n_count         = r_count;
        n_bytes         = r_bytes;
        o_result.valid  = 1'b0;
        o_result.kind   = b32d_pkg::KIND_DATA;
        o_result.data   = '0;
        o_result.count  = '0;

        if (i_sym.is_term) begin
            o_result.valid = 1'b1;
            o_result.kind  = b32d_pkg::KIND_END;
            o_result.count = r_bytes;
            n_store        = '0;
            n_count        = '0;
            n_bytes        = '0;
        end else if (!i_sym.is_sym) begin
            o_result.valid = 1'b1;
            o_result.kind  = b32d_pkg::KIND_ERROR;
            n_store        = '0;
            n_count        = '0;
            n_bytes        = '0;
        end else if (bits >= BITS_W'(b32d_pkg::BYTE_W)) begin
            o_result.valid = 1'b1;
            o_result.data  = shifted[b32d_pkg::BYTE_W-1:0];
            n_store        = b32d_pkg::STORE_W'(acc & mask);
            n_count        = rest[b32d_pkg::CNT_W-1:0];
            if (r_bytes != b32d_pkg::BYTES_MAX) begin
                n_bytes = r_bytes + 1'b1;
            end
        end else begin
            n_store = acc[b32d_pkg::STORE_W-1:0];
            n_count = bits[b32d_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= '0;
            r_count <= '0;
            r_bytes <= '0;
        end else if (i_advance) begin
            r_store <= n_store;
            r_count <= n_count;
            r_bytes <= n_bytes;
        end
    end

endmodule

// ===== rtl/base32_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base32_decoder_top
// Streaming base32 decoder: one character per word in, at most one data,
// end or error word out per character.
//
//   channel | valid        | ready        | payload
//   --------+--------------+--------------+----------------------------------
//   in      | i_in_valid   | o_in_ready   | i_in_char
//   out     | o_out_valid  | i_out_ready  | o_out_byte, o_kind, o_byte_count
//
// one character per cycle sustained while the output is not stalled; a result
// word passes through the input register, then the result register
// reset clears both valid flags and the leftover bit state
// a stalled output holds its word; the input register still drains
// characters that give no result
// ----------------------------------------------------------------------------
module base32_decoder_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [b32d_pkg::CHAR_W-1:0]  i_in_char,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [b32d_pkg::BYTE_W-1:0]  o_out_byte,
    output logic [1:0]                   o_kind,
    output logic [b32d_pkg::BYTES_W-1:0] o_byte_count
);

    logic                        r_in_valid;
    logic [b32d_pkg::CHAR_W-1:0] r_in_char;
    logic                        r_out_valid;
    b32d_pkg::t_result           r_out;

    b32d_pkg::t_sym    sym;
    b32d_pkg::t_result result;
    logic              out_free;
    logic              advance;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (out_free || !result.valid);
    assign o_in_ready = !r_in_valid || advance;

    b32d_symbol_map u_map (
        .i_char (r_in_char),
        .o_sym  (sym)
    );

    b32d_bit_packer u_packer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_sym     (sym),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_char <= i_in_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && advance && result.valid) begin
            r_out <= result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out.data;
    assign o_kind       = r_out.kind;
    assign o_byte_count = r_out.count;

endmodule

// ===== rtl/b32d_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32d_checker
// Port-level checks on the base32 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module b32d_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [b32d_pkg::BYTE_W-1:0]  o_out_byte,
    input logic [1:0]                   o_kind,
    input logic [b32d_pkg::BYTES_W-1:0] o_byte_count
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output word valid or input blocked right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_kind) && $stable(o_byte_count))
        else $error("stalled output word changed");

    a_data_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == b32d_pkg::KIND_DATA) |-> o_byte_count == '0)
        else $error("data word carries a byte count");

    a_end_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == b32d_pkg::KIND_END || o_kind == b32d_pkg::KIND_ERROR)
            |-> o_out_byte == '0)
        else $error("end or error word carries a byte");

    a_error_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == b32d_pkg::KIND_ERROR) |-> o_byte_count == '0)
        else $error("error word carries a byte count");

endmodule

bind base32_decoder_top b32d_checker u_b32d_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_byte   (o_out_byte),
    .o_kind       (o_kind),
    .o_byte_count (o_byte_count)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for base32_decoder_top. A scoreboard class tracks the
// leftover bits and the byte count of the current string, and predicts the
// data, end and error words from every accepted character. Output words are
// checked in order, field by field. The stimulus covers directed edge cases
// and random strings mixed with broken strings and noise. Both sides idle at
// random, and the receiver once holds off long enough for the input to stall.
// ----------------------------------------------------------------------------
typedef struct {
    logic [b32d_pkg::BYTE_W-1:0]  data;
    b32d_pkg::t_kind              kind;
    logic [b32d_pkg::BYTES_W-1:0] count;
} t_word;

function automatic logic is_alpha_char(logic [b32d_pkg::CHAR_W-1:0] c);
    return (c >= b32d_pkg::CHAR_UPPER_A && c <= b32d_pkg::CHAR_UPPER_Z) ||
           (c >= b32d_pkg::CHAR_DIGIT_2 && c <= b32d_pkg::CHAR_DIGIT_7);
endfunction

class b32d_scoreboard;
    logic [b32d_pkg::STORE_W-1:0] bits_held;
    logic [b32d_pkg::CNT_W-1:0]   bits_num;
    logic [b32d_pkg::BYTES_W-1:0] bytes_count;
    t_word                        expected_words[$];
    int unsigned                  mismatches;

    function new();
        bits_held   = '0;
        bits_num    = '0;
        bytes_count = '0;
        mismatches  = 0;
    endfunction

    function void push_word(logic [b32d_pkg::BYTE_W-1:0] data, b32d_pkg::t_kind kind,
                            logic [b32d_pkg::BYTES_W-1:0] count);
        t_word w;
        w.data  = data;
        w.kind  = kind;
        w.count = count;
        expected_words.push_back(w);
    endfunction

    function void note_char(logic [b32d_pkg::CHAR_W-1:0] c);
        logic [b32d_pkg::SYM_W-1:0] sym;
        logic [11:0]                acc;
        int unsigned                total;
        int unsigned                rest;
        if (c == b32d_pkg::CHAR_NUL || c == b32d_pkg::CHAR_PAD) begin
            push_word('0, b32d_pkg::KIND_END, bytes_count);
            bits_held   = '0;
            bits_num    = '0;
            bytes_count = '0;
            return;
        end
        if (!is_alpha_char(c)) begin
            push_word('0, b32d_pkg::KIND_ERROR, '0);
            bits_held   = '0;
            bits_num    = '0;
            bytes_count = '0;
            return;
        end
        if (c <= b32d_pkg::CHAR_UPPER_Z && c >= b32d_pkg::CHAR_UPPER_A) begin
            sym = b32d_pkg::SYM_W'(c - b32d_pkg::CHAR_UPPER_A);
        end else begin
            sym = b32d_pkg::SYM_W'(c - b32d_pkg::CHAR_DIGIT_2) + b32d_pkg::DIGIT_BASE;
        end
        acc   = {bits_held, sym};
        total = bits_num + b32d_pkg::SYM_W;
        if (total >= 8) begin
            rest      = total - 8;
            bits_held = b32d_pkg::STORE_W'(acc & ((12'd1 << rest) - 12'd1));
            bits_num  = b32d_pkg::CNT_W'(rest);
            if (bytes_count != b32d_pkg::BYTES_MAX) begin
                bytes_count = bytes_count + 1'b1;
            end
            push_word(b32d_pkg::BYTE_W'(acc >> rest), b32d_pkg::KIND_DATA, '0);
        end else begin
            bits_held = acc[b32d_pkg::STORE_W-1:0];
            bits_num  = b32d_pkg::CNT_W'(total);
        end
    endfunction

    function void check_word(logic [b32d_pkg::BYTE_W-1:0] data, logic [1:0] kind,
                             logic [b32d_pkg::BYTES_W-1:0] count);
        t_word want;
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected word: data %h kind %0d count %0d",
                     $time, data, kind, count);
            mismatches++;
            return;
        end
        want = expected_words.pop_front();
        if (kind !== want.kind) begin
            $display("%0t: kind mismatch: expected %0d actual %0d",
                     $time, want.kind, kind);
            mismatches++;
        end
        if (data !== want.data) begin
            $display("%0t: data mismatch: expected %h actual %h",
                     $time, want.data, data);
            mismatches++;
        end
        if (count !== want.count) begin
            $display("%0t: count mismatch: expected %0d actual %0d",
                     $time, want.count, count);
            mismatches++;
        end
    endfunction

    function int unsigned pending();
        return expected_words.size();
    endfunction
endclass

module tb_top;

    localparam int unsigned CYCLE_LIMIT    = 2_000_000;
    localparam int unsigned RANDOM_CHARS   = 1750;
    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES   = 10;

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_in_valid   = 1'b0;
    logic                          o_in_ready;
    logic [b32d_pkg::CHAR_W-1:0]   i_in_char    = '0;
    logic                          o_out_valid;
    logic                          i_out_ready  = 1'b0;
    logic [b32d_pkg::BYTE_W-1:0]   o_out_byte;
    logic [1:0]                    o_kind;
    logic [b32d_pkg::BYTES_W-1:0]  o_byte_count;

    b32d_scoreboard sb = new();

    logic        quiet       = 1'b0;
    logic        hold_req    = 1'b0;
    int unsigned rx_stall    = 0;
    int unsigned cycle_count = 0;
    int unsigned chars_sent  = 0;

    base32_decoder_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_char    (i_in_char),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_kind       (o_kind),
        .o_byte_count (o_byte_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [b32d_pkg::CHAR_W-1:0] rand_sym_char();
        int unsigned v;
        v = $urandom_range(0, 31);
        if (v < 26) return b32d_pkg::CHAR_UPPER_A + b32d_pkg::CHAR_W'(v);
        return b32d_pkg::CHAR_DIGIT_2 + b32d_pkg::CHAR_W'(v - 26);
    endfunction

    function automatic logic [b32d_pkg::CHAR_W-1:0] rand_bad_char();
        logic [b32d_pkg::CHAR_W-1:0] c;
        do begin
            c = b32d_pkg::CHAR_W'($urandom_range(0, 255));
        end while (is_alpha_char(c) || c == b32d_pkg::CHAR_NUL || c == b32d_pkg::CHAR_PAD);
        return c;
    endfunction

    // output side: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            rx_stall = RX_HOLD_CYCLES;
        end
        if (rx_stall != 0) begin
            rx_stall--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) begin
                rx_stall = pick_gap();
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_word(o_out_byte, o_kind, o_byte_count);
        end
    end

    // called at a rising edge; returns at the edge that takes the word
    task automatic send_char(input logic [b32d_pkg::CHAR_W-1:0] c);
        int unsigned gap;
        gap = quiet ? 0 : pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_char  <= c;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        sb.note_char(c);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i]);
        end
    endtask

    task automatic send_symbols(input int unsigned n);
        repeat (n) send_char(rand_sym_char());
    endtask

    task automatic send_terminator();
        if ($urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(1, 6)) send_char(b32d_pkg::CHAR_PAD);
        end else begin
            send_char(b32d_pkg::CHAR_NUL);
        end
    endtask

    initial begin
        int unsigned start;
        int unsigned r;
        logic        held;
        held = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // terminators on an empty string, alphabet extremes, all-ones bits
        send_char(b32d_pkg::CHAR_PAD);
        send_char(b32d_pkg::CHAR_NUL);
        send_text("AZ27");
        send_char(b32d_pkg::CHAR_NUL);
        send_text("7777777");
        send_char(b32d_pkg::CHAR_PAD);
        // codes just outside the alphabet, lower case, high codes
        send_text("Q0189@[a");
        send_char(8'hff);
        send_char(8'h80);

        start = chars_sent;
        while (chars_sent - start < RANDOM_CHARS) begin
            if (!held && chars_sent - start >= 700) begin
                held     = 1'b1;
                hold_req = 1'b1;
            end
            quiet = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_symbols(($urandom_range(0, 9) == 0) ? $urandom_range(25, 80)
                                                          : $urandom_range(0, 24));
                send_terminator();
            end else if (r < 85) begin
                send_symbols($urandom_range(0, 12));
                send_char(rand_bad_char());
            end else begin
                repeat ($urandom_range(1, 6))
                    send_char(b32d_pkg::CHAR_W'($urandom_range(0, 255)));
            end
        end
        quiet = 1'b0;
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
